### src/assert_macros.svh
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, ck, rn, prop) \
	name: assert property (@(posedge ck) disable iff (!rn) (prop)) \
	else $error("assertion failed: invariant");

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(name, ck, rn, pre, post) \
	name: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
	else $error("assertion failed: next-cycle implication");

`endif

### src/bits_pkg.sv
// Types, constants and helpers for the budgeted interval tick scheduler
`default_nettype none

package bits_pkg;

	localparam int CLIENTS    = 256;
	localparam int CLI_W      = $clog2(CLIENTS);
	localparam int ID_W       = 8;
	localparam int DT_W       = 16;
	localparam int ACC_W      = 20;
	localparam int IVL_W      = 16;
	localparam int MAXT_W     = 9;
	localparam int TD_W       = 21;
	localparam int C16_W      = 16;
	localparam int C32_W      = 32;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIV_CNT_W  = $clog2(ID_W);
	localparam int ALU_W      = ACC_W + 2;

	localparam logic [ACC_W-1:0]  ACC_MAX       = {ACC_W{1'b1}};
	localparam logic [IVL_W-1:0]  IVL_RESET     = IVL_W'(50);
	localparam logic [MAXT_W-1:0] MAXT_RESET    = MAXT_W'(8);

	typedef enum logic [CMD_W-1:0] {
		CMD_FRAME   = 2'd0,
		CMD_REQUEST = 2'd1,
		CMD_REMOVE  = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLED   = 2'd0,
		CFG_INTERVAL  = 2'd1,
		CFG_MAX_TICKS = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_ADD,
		ST_DONE
	} state_t;

	function automatic logic [C16_W-1:0] inc16(input logic [C16_W-1:0] v);
		return (&v) ? v : v + C16_W'(1);
	endfunction

	function automatic logic [C32_W-1:0] inc32(input logic [C32_W-1:0] v);
		return (&v) ? v : v + C32_W'(1);
	endfunction

endpackage

`default_nettype wire

### src/budgeted_interval_tick_scheduler_top.sv
// Budgeted interval tick scheduler: client table, shared add/subtract unit, sequencer
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  cfg     | cfg_en, cfg_index, cfg_data           | in, write only
//  in      | in_valid/in_ready: cmd, client_id,    | in
//          |   delta_time                          |
//  out     | out_valid/out_ready: tick, tick_delta,| out
//          |   frame and total counters            |
//
// Frame start, removal, clear, disabled or out-of-table request: straight to the decide step.
// Request from a present client: table read, add, decide.
// First request from a client: remainder, add, decide; the remainder
// client_id mod tick_interval takes one restoring step per cycle in the shared unit.
// One item at a time; the decide step holds while the previous result is not taken.
// Reset clears all present bits at once; no clearing pass.
`default_nettype none

module budgeted_interval_tick_scheduler_top (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      cfg_en,
	input  wire  [bits_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire  [bits_pkg::CFG_DATA_W-1:0]          cfg_data,
	input  wire                                      in_valid,
	output logic                                     in_ready,
	input  wire  [bits_pkg::CMD_W-1:0]               cmd,
	input  wire  [bits_pkg::ID_W-1:0]                client_id,
	input  wire  signed [bits_pkg::DT_W-1:0]         delta_time,
	output logic                                     out_valid,
	input  wire                                      out_ready,
	output logic                                     tick,
	output logic signed [bits_pkg::TD_W-1:0]         tick_delta,
	output logic [bits_pkg::C32_W-1:0]               frame_count,
	output logic [bits_pkg::C16_W-1:0]               ticked_in_frame,
	output logic [bits_pkg::C16_W-1:0]               skipped_in_frame,
	output logic [bits_pkg::C16_W-1:0]               pending_in_frame,
	output logic [bits_pkg::C32_W-1:0]               total_ticked,
	output logic [bits_pkg::C32_W-1:0]               total_skipped
);

	bits_pkg::state_t state_q, state_nxt;

	logic                              enabled_q;
	logic [bits_pkg::IVL_W-1:0]        interval_q;
	logic [bits_pkg::MAXT_W-1:0]       max_ticks_q;

	bits_pkg::cmd_t                    cmd_q;
	logic [bits_pkg::ID_W-1:0]         id_q;
	logic signed [bits_pkg::DT_W-1:0]  delta_q;

	logic [bits_pkg::CLIENTS-1:0]      present_q;
	logic [bits_pkg::ACC_W-1:0]        acc_mem [bits_pkg::CLIENTS];
	logic [bits_pkg::ACC_W-1:0]        mem_rd_q;
	logic [bits_pkg::ACC_W-1:0]        acc_q;

	logic [bits_pkg::IVL_W-1:0]        rem_q;
	logic [bits_pkg::ID_W-1:0]         div_sh_q;
	logic [bits_pkg::DIV_CNT_W-1:0]    div_cnt_q;

	logic [bits_pkg::C32_W-1:0]        frame_count_q;
	logic [bits_pkg::C16_W-1:0]        ticked_q;
	logic [bits_pkg::C16_W-1:0]        skipped_q;
	logic [bits_pkg::C16_W-1:0]        pending_q;
	logic [bits_pkg::C32_W-1:0]        tot_ticked_q;
	logic [bits_pkg::C32_W-1:0]        tot_skipped_q;

	logic                              out_valid_q;
	logic                              tick_q;
	logic signed [bits_pkg::TD_W-1:0]  tick_delta_q;

	logic                              in_fire;
	logic                              out_free;
	logic                              done_go;
	logic [bits_pkg::IVL_W-1:0]        ivl_eff;
	logic [bits_pkg::MAXT_W-1:0]       budget_eff;
	logic [bits_pkg::CLI_W-1:0]        in_idx;
	logic [bits_pkg::CLI_W-1:0]        idx;
	logic                              in_range_in;
	logic                              in_range;
	logic                              req_work;
	logic                              new_work;

	logic [bits_pkg::ALU_W-1:0]        alu_a;
	logic [bits_pkg::ALU_W-1:0]        alu_b;
	logic                              alu_sub;
	logic [bits_pkg::ALU_W-1:0]        alu_y;

	logic [bits_pkg::IVL_W:0]          div_trial;
	logic [bits_pkg::IVL_W-1:0]        rem_nxt;
	logic [bits_pkg::ALU_W-1:0]        delta_pos;
	logic [bits_pkg::ACC_W-1:0]        acc_sum;
	logic                              below;
	logic                              over_budget;
	logic                              grant;

	assign ivl_eff    = (interval_q == '0) ? bits_pkg::IVL_W'(1) : interval_q;
	assign budget_eff = (max_ticks_q == '0) ? bits_pkg::MAXT_W'(1) : max_ticks_q;

	assign in_fire  = in_valid & in_ready;
	assign out_free = !out_valid_q | out_ready;

	assign in_idx      = bits_pkg::CLI_W'(client_id);
	assign idx         = bits_pkg::CLI_W'(id_q);
	assign in_range_in = 32'(client_id) < 32'(bits_pkg::CLIENTS);
	assign in_range    = 32'(id_q) < 32'(bits_pkg::CLIENTS);
	assign req_work    = (cmd_q == bits_pkg::CMD_REQUEST) && enabled_q && in_range;
	assign new_work    = (bits_pkg::cmd_t'(cmd) == bits_pkg::CMD_REQUEST) && enabled_q
		&& in_range_in;

	// shared add/subtract unit
	assign delta_pos = delta_q[bits_pkg::DT_W-1] ? '0 :
		bits_pkg::ALU_W'($unsigned(delta_q));
	assign div_trial = {rem_q, div_sh_q[bits_pkg::ID_W-1]};
	assign alu_y     = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

	assign rem_nxt = alu_y[bits_pkg::ALU_W-1] ? div_trial[bits_pkg::IVL_W-1:0]
		: alu_y[bits_pkg::IVL_W-1:0];
	assign acc_sum = (|alu_y[bits_pkg::ALU_W-1:bits_pkg::ACC_W]) ? bits_pkg::ACC_MAX
		: alu_y[bits_pkg::ACC_W-1:0];

	assign below       = alu_y[bits_pkg::ALU_W-1];
	assign over_budget = ticked_q >= bits_pkg::C16_W'(budget_eff);
	assign grant       = req_work && !below && !over_budget;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bits_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (!new_work)
						state_nxt = bits_pkg::ST_DONE;
					else if (present_q[in_idx])
						state_nxt = bits_pkg::ST_LOAD;
					else
						state_nxt = bits_pkg::ST_DIV;
				end
			end
			bits_pkg::ST_LOAD: state_nxt = bits_pkg::ST_ADD;
			bits_pkg::ST_DIV: begin
				if (div_cnt_q == '0)
					state_nxt = bits_pkg::ST_ADD;
			end
			bits_pkg::ST_ADD: state_nxt = bits_pkg::ST_DONE;
			bits_pkg::ST_DONE: begin
				if (out_free)
					state_nxt = bits_pkg::ST_IDLE;
			end
			default: state_nxt = bits_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		done_go  = 1'b0;
		alu_a    = bits_pkg::ALU_W'(acc_q);
		alu_b    = bits_pkg::ALU_W'(ivl_eff);
		alu_sub  = 1'b1;
		case (state_q)
			bits_pkg::ST_IDLE: in_ready = 1'b1;
			bits_pkg::ST_DIV: begin
				alu_a = bits_pkg::ALU_W'(div_trial);
			end
			bits_pkg::ST_ADD: begin
				alu_b   = delta_pos;
				alu_sub = 1'b0;
			end
			bits_pkg::ST_DONE: done_go = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bits_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// item and datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q     <= bits_pkg::cmd_t'(cmd);
			id_q      <= client_id;
			delta_q   <= delta_time;
			rem_q     <= '0;
			div_sh_q  <= client_id;
			div_cnt_q <= bits_pkg::DIV_CNT_W'(bits_pkg::ID_W - 1);
		end
		if (state_q == bits_pkg::ST_DIV) begin
			rem_q     <= rem_nxt;
			div_sh_q  <= div_sh_q << 1;
			div_cnt_q <= div_cnt_q - bits_pkg::DIV_CNT_W'(1);
			if (div_cnt_q == '0)
				acc_q <= bits_pkg::ACC_W'(rem_nxt);
		end
		if (state_q == bits_pkg::ST_LOAD)
			acc_q <= mem_rd_q;
		if (state_q == bits_pkg::ST_ADD)
			acc_q <= acc_sum;
	end

	// accumulator table
	always_ff @(posedge clk) begin
		if (in_fire)
			mem_rd_q <= acc_mem[in_idx];
	end

	always_ff @(posedge clk) begin
		if (done_go && req_work)
			acc_mem[idx] <= grant ? '0 : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (done_go) begin
			if (req_work)
				present_q[idx] <= 1'b1;
			else if (cmd_q == bits_pkg::CMD_REMOVE && in_range)
				present_q[idx] <= 1'b0;
			else if (cmd_q == bits_pkg::CMD_CLEAR)
				present_q <= '0;
		end
	end

	// configuration and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q     <= 1'b0;
			interval_q    <= bits_pkg::IVL_RESET;
			max_ticks_q   <= bits_pkg::MAXT_RESET;
			frame_count_q <= '0;
			ticked_q      <= '0;
			skipped_q     <= '0;
			pending_q     <= '0;
			tot_ticked_q  <= '0;
			tot_skipped_q <= '0;
		end else if (cfg_en) begin
			case (bits_pkg::cfg_idx_t'(cfg_index))
				bits_pkg::CFG_ENABLED: begin
					enabled_q <= cfg_data[0];
					if (!cfg_data[0]) begin
						ticked_q  <= '0;
						skipped_q <= '0;
						pending_q <= '0;
					end
				end
				bits_pkg::CFG_INTERVAL:  interval_q  <= cfg_data[bits_pkg::IVL_W-1:0];
				bits_pkg::CFG_MAX_TICKS: max_ticks_q <= cfg_data[bits_pkg::MAXT_W-1:0];
				default: ;
			endcase
		end else if (done_go) begin
			case (cmd_q)
				bits_pkg::CMD_FRAME: begin
					frame_count_q <= frame_count_q + bits_pkg::C32_W'(1);
					ticked_q      <= '0;
					skipped_q     <= '0;
					pending_q     <= '0;
				end
				bits_pkg::CMD_REQUEST: begin
					if (req_work) begin
						if (below) begin
							pending_q <= bits_pkg::inc16(pending_q);
						end else if (over_budget) begin
							skipped_q     <= bits_pkg::inc16(skipped_q);
							pending_q     <= bits_pkg::inc16(pending_q);
							tot_skipped_q <= bits_pkg::inc32(tot_skipped_q);
						end else begin
							ticked_q     <= bits_pkg::inc16(ticked_q);
							tot_ticked_q <= bits_pkg::inc32(tot_ticked_q);
						end
					end
				end
				bits_pkg::CMD_CLEAR: begin
					ticked_q      <= '0;
					skipped_q     <= '0;
					pending_q     <= '0;
					tot_ticked_q  <= '0;
					tot_skipped_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (done_go)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			if (cmd_q == bits_pkg::CMD_REQUEST && !enabled_q) begin
				tick_q       <= 1'b1;
				tick_delta_q <= bits_pkg::TD_W'(delta_q);
			end else if (grant) begin
				tick_q       <= 1'b1;
				tick_delta_q <= bits_pkg::TD_W'(acc_q);
			end else begin
				tick_q       <= 1'b0;
				tick_delta_q <= '0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign tick             = tick_q;
	assign tick_delta       = tick_delta_q;
	assign frame_count      = frame_count_q;
	assign ticked_in_frame  = ticked_q;
	assign skipped_in_frame = skipped_q;
	assign pending_in_frame = pending_q;
	assign total_ticked     = tot_ticked_q;
	assign total_skipped    = tot_skipped_q;

endmodule

`default_nettype wire

### src/bits_sva.sv
// Port-level checker for the budgeted interval tick scheduler, with its bind
`default_nettype none

`include "assert_macros.svh"

module bits_sva (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                in_valid,
	input wire                                in_ready,
	input wire                                out_valid,
	input wire                                out_ready,
	input wire                                tick,
	input wire signed [bits_pkg::TD_W-1:0]    tick_delta,
	input wire [bits_pkg::C32_W-1:0]          frame_count,
	input wire [bits_pkg::C16_W-1:0]          skipped_in_frame,
	input wire [bits_pkg::C16_W-1:0]          pending_in_frame
);

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(tick) && $stable(tick_delta))
	`ASSERT_ALWAYS(a_skip_le_pending, clk, arst_n, skipped_in_frame <= pending_in_frame)
	`ASSERT_ALWAYS(a_frame_step, clk, arst_n, frame_count == $past(frame_count) || frame_count == $past(frame_count) + 32'd1)

endmodule

bind budgeted_interval_tick_scheduler_top bits_sva u_bits_sva (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.tick             (tick),
	.tick_delta       (tick_delta),
	.frame_count      (frame_count),
	.skipped_in_frame (skipped_in_frame),
	.pending_in_frame (pending_in_frame)
);

`default_nettype wire

### sim/budgeted_interval_tick_scheduler_top_tb.sv
// Self-checking testbench for the budgeted interval tick scheduler top level
`timescale 1ns / 100ps

module budgeted_interval_tick_scheduler_top_tb;
	import bits_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SAT_ITEMS      = 60;
	localparam int MAX_PRINTS     = 50;

	typedef struct packed {
		logic              tick;
		logic [TD_W-1:0]   tick_delta;
		logic [C32_W-1:0]  frame_count;
		logic [C16_W-1:0]  ticked;
		logic [C16_W-1:0]  skipped;
		logic [C16_W-1:0]  pending;
		logic [C32_W-1:0]  total_ticked;
		logic [C32_W-1:0]  total_skipped;
	} grant_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         cfg_en     = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index  = '0;
	logic [CFG_DATA_W-1:0]        cfg_data   = '0;
	logic                         in_valid   = 1'b0;
	wire                          in_ready;
	logic [CMD_W-1:0]             cmd        = '0;
	logic [ID_W-1:0]              client_id  = '0;
	logic signed [DT_W-1:0]       delta_time = '0;
	wire                          out_valid;
	logic                         out_ready  = 1'b0;
	wire                          tick;
	wire signed [TD_W-1:0]        tick_delta;
	wire [C32_W-1:0]              frame_count;
	wire [C16_W-1:0]              ticked_in_frame;
	wire [C16_W-1:0]              skipped_in_frame;
	wire [C16_W-1:0]              pending_in_frame;
	wire [C32_W-1:0]              total_ticked;
	wire [C32_W-1:0]              total_skipped;

	// scheduler mirror
	logic                  mir_en;
	logic [IVL_W-1:0]      mir_ivl;
	logic [MAXT_W-1:0]     mir_maxt;
	logic                  mir_seen [CLIENTS];
	logic [ACC_W-1:0]      mir_acc  [CLIENTS];
	logic [C32_W-1:0]      mir_frames;
	logic [C16_W-1:0]      mir_ticked;
	logic [C16_W-1:0]      mir_skipped;
	logic [C16_W-1:0]      mir_pending;
	logic [C32_W-1:0]      mir_sum_ticked;
	logic [C32_W-1:0]      mir_sum_skipped;

	grant_t grant_q[$];
	int     errors;
	int     n_items;
	int     n_checked;
	int     n_granted;
	int     n_writes;
	int     tx_idle_pct;
	int     rx_stall_pct = 0;
	logic   rx_hold      = 1'b0;
	int     quiet_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	budgeted_interval_tick_scheduler_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_en           (cfg_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.cmd              (cmd),
		.client_id        (client_id),
		.delta_time       (delta_time),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.tick             (tick),
		.tick_delta       (tick_delta),
		.frame_count      (frame_count),
		.ticked_in_frame  (ticked_in_frame),
		.skipped_in_frame (skipped_in_frame),
		.pending_in_frame (pending_in_frame),
		.total_ticked     (total_ticked),
		.total_skipped    (total_skipped)
	);

	function automatic logic [C16_W-1:0] bump16(input logic [C16_W-1:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [C32_W-1:0] bump32(input logic [C32_W-1:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic int interval_eff();
		return (mir_ivl == '0) ? 1 : int'(mir_ivl);
	endfunction

	task automatic clear_frame_counts();
		mir_ticked  = '0;
		mir_skipped = '0;
		mir_pending = '0;
	endtask

	task automatic predict_grant(input cmd_t c, input logic [ID_W-1:0] id,
			input logic signed [DT_W-1:0] dt, output grant_t g);
		logic [16:0]     ivl_e;
		logic [9:0]      budget;
		logic [TD_W-1:0] sum;
		g      = '0;
		ivl_e  = 17'(interval_eff());
		budget = (mir_maxt == '0) ? 10'd1 : {1'b0, mir_maxt};
		case (c)
			CMD_FRAME: begin
				mir_frames = mir_frames + 32'd1;
				clear_frame_counts();
			end
			CMD_REQUEST: begin
				if (!mir_en) begin
					g.tick       = 1'b1;
					g.tick_delta = {{(TD_W-DT_W){dt[DT_W-1]}}, dt};
				end else if (int'(id) < CLIENTS) begin
					if (!mir_seen[id]) begin
						mir_seen[id] = 1'b1;
						mir_acc[id]  = ACC_W'(int'(id) % int'(ivl_e));
					end
					sum = {1'b0, mir_acc[id]};
					if (dt > 0)
						sum = sum + TD_W'(dt);
					if (sum > TD_W'(ACC_MAX))
						sum = TD_W'(ACC_MAX);
					mir_acc[id] = sum[ACC_W-1:0];
					if (sum < TD_W'(ivl_e)) begin
						mir_pending = bump16(mir_pending);
					end else if (mir_ticked >= C16_W'(budget)) begin
						mir_skipped     = bump16(mir_skipped);
						mir_pending     = bump16(mir_pending);
						mir_sum_skipped = bump32(mir_sum_skipped);
					end else begin
						g.tick         = 1'b1;
						g.tick_delta   = sum;
						mir_acc[id]    = '0;
						mir_ticked     = bump16(mir_ticked);
						mir_sum_ticked = bump32(mir_sum_ticked);
					end
				end
			end
			CMD_REMOVE: begin
				if (int'(id) < CLIENTS) begin
					mir_seen[id] = 1'b0;
					mir_acc[id]  = '0;
				end
			end
			default: begin
				for (int i = 0; i < CLIENTS; i++) begin
					mir_seen[i] = 1'b0;
					mir_acc[i]  = '0;
				end
				clear_frame_counts();
				mir_sum_ticked  = '0;
				mir_sum_skipped = '0;
			end
		endcase
		g.frame_count   = mir_frames;
		g.ticked        = mir_ticked;
		g.skipped       = mir_skipped;
		g.pending       = mir_pending;
		g.total_ticked  = mir_sum_ticked;
		g.total_skipped = mir_sum_skipped;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("MISMATCH %s: got %0h want %0h at result %0d", what, got, want,
				n_checked);
	endtask

	task automatic check_grant();
		grant_t w;
		if (grant_q.size() == 0) begin
			report_mismatch("unexpected item", 32'(tick), 32'd0);
		end else begin
			w = grant_q.pop_front();
			if (tick !== w.tick)
				report_mismatch("tick", 32'(tick), 32'(w.tick));
			if (tick_delta !== w.tick_delta)
				report_mismatch("tick_delta", 32'(tick_delta), 32'(w.tick_delta));
			if (frame_count !== w.frame_count)
				report_mismatch("frame_count", frame_count, w.frame_count);
			if (ticked_in_frame !== w.ticked)
				report_mismatch("ticked_in_frame", 32'(ticked_in_frame), 32'(w.ticked));
			if (skipped_in_frame !== w.skipped)
				report_mismatch("skipped_in_frame", 32'(skipped_in_frame), 32'(w.skipped));
			if (pending_in_frame !== w.pending)
				report_mismatch("pending_in_frame", 32'(pending_in_frame), 32'(w.pending));
			if (total_ticked !== w.total_ticked)
				report_mismatch("total_ticked", total_ticked, w.total_ticked);
			if (total_skipped !== w.total_skipped)
				report_mismatch("total_skipped", total_skipped, w.total_skipped);
			if (w.tick)
				n_granted++;
		end
		n_checked++;
	endtask

	// result side: random stalls, plus a hold-off driven by the pressure test
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_grant();
		out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_item(input cmd_t c, input logic [ID_W-1:0] id,
			input logic signed [DT_W-1:0] dt);
		int     gap;
		grant_t g;
		gap = ($urandom_range(0, 99) < tx_idle_pct) ? int'($urandom_range(1, 6)) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		client_id  <= id;
		delta_time <= dt;
		do @(posedge clk); while (!in_ready);
		predict_grant(c, id, dt, g);
		grant_q.push_back(g);
		n_items++;
	endtask

	// called in the step of the last acceptance, so valid drops at once
	task automatic drain();
		in_valid <= 1'b0;
		while (grant_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_en    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_en    <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_ENABLED: begin
				mir_en = data[0];
				if (!mir_en)
					clear_frame_counts();
			end
			CFG_INTERVAL:  mir_ivl  = data[IVL_W-1:0];
			CFG_MAX_TICKS: mir_maxt = data[MAXT_W-1:0];
			default: ;
		endcase
		n_writes++;
	endtask

	function automatic logic signed [DT_W-1:0] rand_delta(input int span);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return DT_W'($urandom_range(0, span));
			5, 6:          return DT_W'(-int'($urandom_range(1, 32768)));
			7, 8:          return DT_W'($urandom);
			default: begin
				case ($urandom_range(0, 3))
					0:       return 16'sh7FFF;
					1:       return 16'sh8000;
					2:       return 16'sh0000;
					default: return 16'sh0001;
				endcase
			end
		endcase
	endfunction

	task automatic rand_config();
		logic [CFG_DATA_W-1:0] ivl;
		logic [CFG_DATA_W-1:0] maxt;
		case ($urandom_range(0, 6))
			0:       ivl = 16'd0;
			1:       ivl = 16'd1;
			2:       ivl = 16'($urandom_range(2, 100));
			3:       ivl = 16'd50;
			4:       ivl = 16'($urandom_range(100, 5000));
			5:       ivl = 16'($urandom);
			default: ivl = 16'hFFFF;
		endcase
		case ($urandom_range(0, 5))
			0:       maxt = 16'd0;
			1:       maxt = 16'd1;
			2, 3:    maxt = 16'($urandom_range(2, 16));
			4:       maxt = 16'($urandom_range(17, 255));
			default: maxt = 16'd256;
		endcase
		if ($urandom_range(0, 3) == 0)
			cfg_write(CFG_ENABLED, 16'd0);
		cfg_write(CFG_INTERVAL, ivl);
		cfg_write(CFG_MAX_TICKS, maxt);
		cfg_write(CFG_ENABLED, ($urandom_range(0, 9) != 0) ? 16'd1 : 16'd0);
	endtask

	task automatic send_random_items(input int count);
		int              r;
		int              span;
		logic [ID_W-1:0] base;
		logic [ID_W-1:0] id;
		cmd_t            c;
		base = ID_W'($urandom);
		span = (interval_eff() > 32767) ? 32767 : interval_eff();
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				c = CMD_FRAME;
			else if (r < 88)
				c = CMD_REQUEST;
			else if (r < 97)
				c = CMD_REMOVE;
			else
				c = CMD_CLEAR;
			if ($urandom_range(0, 9) < 7)
				id = base + ID_W'($urandom_range(0, 7));
			else
				id = ID_W'($urandom);
			send_item(c, id, rand_delta(span));
		end
	endtask

	task automatic test_disabled();
		tx_idle_pct = 0;
		send_item(CMD_REQUEST, 8'd0, 16'sh7FFF);
		send_item(CMD_REQUEST, 8'd255, 16'sh8000);
		send_item(CMD_REQUEST, 8'd1, 16'sh0000);
		send_item(CMD_REQUEST, 8'd2, -16'sd1);
		send_item(CMD_FRAME, 8'd0, 16'sh0000);
		send_item(CMD_REMOVE, 8'd3, 16'sh0000);
		send_item(CMD_CLEAR, 8'd0, 16'sh0000);
		drain();
	endtask

	task automatic test_enabled_basics();
		cfg_write(CFG_ENABLED, 16'd1);
		send_item(CMD_REQUEST, 8'd255, 16'sd0);
		send_item(CMD_REQUEST, 8'd255, 16'sd45);
		send_item(CMD_REQUEST, 8'd0, -16'sd5);
		send_item(CMD_REQUEST, 8'd0, 16'sh7FFF);
		send_item(CMD_REQUEST, 8'd0, 16'sd49);
		send_item(CMD_REQUEST, 8'd0, 16'sd1);
		send_item(CMD_REMOVE, 8'd0, 16'sd0);
		send_item(CMD_REQUEST, 8'd0, 16'sd60);
		send_item(CMD_REMOVE, 8'd200, 16'sd0);
		send_item(CMD_FRAME, 8'd0, 16'sd0);
		send_item(CMD_CLEAR, 8'd0, 16'sd0);
		send_item(CMD_REQUEST, 8'd255, 16'sd45);
		drain();
	endtask

	task automatic test_register_extremes();
		// zero interval and zero budget behave as one
		cfg_write(CFG_INTERVAL, 16'd0);
		cfg_write(CFG_MAX_TICKS, 16'd0);
		send_item(CMD_FRAME, 8'd0, 16'sd0);
		send_item(CMD_REQUEST, 8'd10, 16'sd0);
		send_item(CMD_REQUEST, 8'd10, 16'sd1);
		send_item(CMD_REQUEST, 8'd11, 16'sd5);
		send_item(CMD_FRAME, 8'd0, 16'sd0);
		send_item(CMD_REQUEST, 8'd11, 16'sd0);
		drain();
		cfg_write(CFG_INTERVAL, 16'hFFFF);
		cfg_write(CFG_MAX_TICKS, 16'd256);
		send_item(CMD_REQUEST, 8'd254, 16'sh7FFF);
		send_item(CMD_REQUEST, 8'd254, 16'sh7FFF);
		send_item(CMD_REQUEST, 8'd254, 16'sh8000);
		drain();
		// disabling clears frame counters only
		cfg_write(CFG_ENABLED, 16'd0);
		send_item(CMD_REQUEST, 8'd3, 16'sd100);
		drain();
		cfg_write(CFG_ENABLED, 16'd1);
		send_item(CMD_REQUEST, 8'd3, 16'sd0);
		drain();
	endtask

	task automatic test_saturation();
		// budget of one: after one grant the client only accumulates and is skipped
		cfg_write(CFG_INTERVAL, 16'd1000);
		cfg_write(CFG_MAX_TICKS, 16'd1);
		cfg_write(CFG_ENABLED, 16'd1);
		tx_idle_pct  = 0;
		rx_stall_pct <= 0;
		send_item(CMD_FRAME, 8'd0, 16'sd0);
		send_item(CMD_REQUEST, 8'd7, 16'sh7FFF);
		for (int i = 0; i < SAT_ITEMS; i++)
			send_item(CMD_REQUEST, 8'd7,
				(i % 16 == 15) ? rand_delta(100) : 16'(16'h7000 + $urandom_range(0, 4095)));
		send_item(CMD_FRAME, 8'd0, 16'sd0);
		send_item(CMD_REQUEST, 8'd7, 16'sd0);
		drain();
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct,
			input int count);
		tx_idle_pct  = idle_pct;
		rx_stall_pct <= stall_pct;
		for (int done = 0; done < count; done += 70) begin
			rand_config();
			send_random_items(70);
			drain();
		end
	endtask

	task automatic test_backpressure();
		tx_idle_pct  = 0;
		rx_stall_pct <= 0;
		cfg_write(CFG_INTERVAL, 16'd20);
		cfg_write(CFG_MAX_TICKS, 16'd4);
		cfg_write(CFG_ENABLED, 16'd1);
		fork
			begin
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		send_random_items(80);
		drain();
	endtask

	initial begin
		mir_en          = 1'b0;
		mir_ivl         = IVL_RESET;
		mir_maxt        = MAXT_RESET;
		mir_frames      = '0;
		mir_sum_ticked  = '0;
		mir_sum_skipped = '0;
		clear_frame_counts();
		for (int i = 0; i < CLIENTS; i++) begin
			mir_seen[i] = 1'b0;
			mir_acc[i]  = '0;
		end
		errors       = 0;
		n_items      = 0;
		n_checked    = 0;
		n_granted    = 0;
		n_writes     = 0;
		tx_idle_pct  = 0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled();
		test_enabled_basics();
		test_register_extremes();
		test_random_phase(0, 0, 350);
		test_random_phase(65, 0, 350);
		test_random_phase(0, 65, 350);
		test_random_phase(34, 34, 350);
		test_backpressure();
		test_saturation();
		drain();
		repeat (20) @(posedge clk);

		$display("run: %0d items sent, %0d results checked, %0d grants, %0d register writes",
			n_items, n_checked, n_granted, n_writes);
		$display("covered: disabled mode, register extremes, idle/stall mixes, long output",
			" hold-off, accumulator saturation under a budget of one");
		if (errors == 0 && grant_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/bits_pkg.sv
src/budgeted_interval_tick_scheduler_top.sv
src/bits_sva.sv
sim/budgeted_interval_tick_scheduler_top_tb.sv
